// ----- design/escape_count_palette_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef ESCAPE_COUNT_PALETTE_ASSERT_SVH
`define ESCAPE_COUNT_PALETTE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ECP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ECP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/ecp_pkg.sv -----
package ecp_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT    = 2'd1;

	localparam logic [15:0] MAX_COUNT_RST = 16'd256;

	// divider: 9 integer quotient bits, 16 fraction bits
	localparam int INT_STEPS  = 9;
	localparam int FRAC_STEPS = 16;
	localparam int DIV_STEPS  = INT_STEPS + FRAC_STEPS;
	localparam int QW         = DIV_STEPS;	// quotient / remainder width

	localparam int POST_STAGES = 5;

	localparam logic [QW-1:0] DEG_FULL = QW'(360);

	// hue constants, Q9.16 degrees
	localparam logic [25:0] HUE_ROT   = 26'd172 << 16;
	localparam logic [25:0] HUE_FULL  = 26'd360 << 16;
	localparam logic [24:0] SEC_SPAN  = 25'd60 << 16;

	// floor(x/15) = (x * RECIP15) >> 23, exact for x < 2^20
	localparam logic [19:0] RECIP15 = 20'd559241;

	localparam logic [7:0] V_BYTE = 8'd191;
	localparam logic [7:0] P_BYTE = 8'd19;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

endpackage

// ----- design/ecp_div.sv -----
module ecp_div import ecp_pkg::*; (
	input  logic                 clk,
	input  logic [DIV_STEPS-1:0] en,
	input  logic [QW-1:0]        x_in,
	input  logic [15:0]          mc,
	output logic [QW-1:0]        quo
);

	// one restoring step per stage
	logic [QW-1:0] rem_s [0:DIV_STEPS-2];
	logic [QW-1:0] quo_s [0:DIV_STEPS-1];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [QW-1:0] rem_in, quo_in, trial, dvs, rem_nx;
		logic          bit_nx;

		if (j == 0) begin : g_first
			assign rem_in = x_in;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		if (j < INT_STEPS) begin : g_int
			assign trial = rem_in;
			assign dvs   = QW'(mc) << (INT_STEPS - 1 - j);
		end else begin : g_frac
			assign trial = rem_in << 1;
			assign dvs   = QW'(mc);
		end

		assign bit_nx = trial >= dvs;
		assign rem_nx = bit_nx ? trial - dvs : trial;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				quo_s[j] <= {quo_in[QW-2:0], bit_nx};
			end
		end

		if (j < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j] <= rem_nx;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule

// ----- design/ecp_hue.sv -----
module ecp_hue import ecp_pkg::*; (
	input  logic                   clk,
	input  logic [POST_STAGES-1:0] en,
	input  logic [QW-1:0]          quo,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);

	logic [24:0] h_s1;
	sector_t     sec_s2, sec_s3, sec_s4;
	logic [21:0] y_s2;
	logic [39:0] prod_s3;
	logic [19:0] wq_s4, wt_s4;

	logic [25:0] h_sum;
	logic [24:0] h_wrap;
	sector_t     sec_nx;
	logic [24:0] sec_base;
	logic [15:0] f;
	logic [19:0] f9;
	logic [27:0] qm, tm;
	logic [7:0]  qb, tb;

	assign h_sum  = 26'(quo) + HUE_ROT;
	assign h_wrap = (h_sum >= HUE_FULL) ? 25'(h_sum - HUE_FULL) : h_sum[24:0];

	always_comb begin
		if (h_s1 >= 25'(5 * SEC_SPAN)) begin
			sec_nx = SEC_5;
			sec_base = 25'(5 * SEC_SPAN);
		end else if (h_s1 >= 25'(4 * SEC_SPAN)) begin
			sec_nx = SEC_4;
			sec_base = 25'(4 * SEC_SPAN);
		end else if (h_s1 >= 25'(3 * SEC_SPAN)) begin
			sec_nx = SEC_3;
			sec_base = 25'(3 * SEC_SPAN);
		end else if (h_s1 >= 25'(2 * SEC_SPAN)) begin
			sec_nx = SEC_2;
			sec_base = 25'(2 * SEC_SPAN);
		end else if (h_s1 >= SEC_SPAN) begin
			sec_nx = SEC_1;
			sec_base = SEC_SPAN;
		end else begin
			sec_nx = SEC_0;
			sec_base = '0;
		end
	end

	// f = floor(y/60) = floor(floor(y/4)/15)
	assign f  = prod_s3[38:23];
	assign f9 = 20'(f) * 20'd9;

	// 765/(40*2^16) reduces to 153/2^19
	assign qm = 28'(wq_s4) * 28'd153;
	assign tm = 28'(wt_s4) * 28'd153;
	assign qb = qm[26:19];
	assign tb = tm[26:19];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			h_s1 <= h_wrap;
		end
		if (en[1]) begin
			sec_s2 <= sec_nx;
			y_s2   <= 22'(h_s1 - sec_base);
		end
		if (en[2]) begin
			sec_s3  <= sec_s2;
			prod_s3 <= 40'(y_s2[21:2]) * 40'(RECIP15);
		end
		if (en[3]) begin
			sec_s4 <= sec_s3;
			wq_s4  <= 20'd655360 - f9;
			wt_s4  <= 20'd65536 + f9;
		end
		if (en[4]) begin
			case (sec_s4)
				SEC_0: begin red <= V_BYTE; green <= tb; blue <= P_BYTE; end
				SEC_1: begin red <= qb; green <= V_BYTE; blue <= P_BYTE; end
				SEC_2: begin red <= P_BYTE; green <= V_BYTE; blue <= tb; end
				SEC_3: begin red <= P_BYTE; green <= qb; blue <= V_BYTE; end
				SEC_4: begin red <= tb; green <= P_BYTE; blue <= V_BYTE; end
				default: begin red <= V_BYTE; green <= P_BYTE; blue <= qb; end
			endcase
		end
	end

endmodule

// ----- design/ecp_poly.sv -----
module ecp_poly import ecp_pkg::*; (
	input  logic                   clk,
	input  logic [POST_STAGES-1:0] en,
	input  logic [QW-1:0]          quo,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);

	logic [15:0] t_s1;
	logic [16:0] u_s1;
	logic [30:0] p_s2;
	logic [31:0] t2_s2;
	logic [32:0] u2_s2;
	logic [62:0] xr_s3;
	logic [61:0] xg_s3;
	logic [63:0] xb_s3;
	logic [74:0] yr_s4;
	logic [73:0] yg_s4;
	logic [76:0] yb_s4;

	logic [32:0] ut_full;

	// U*T peaks at 2^30 since U+T = 2^16
	assign ut_full = 33'(u_s1) * 33'(t_s1);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1 <= quo[15:0];
			u_s1 <= 17'h10000 - 17'(quo[15:0]);
		end
		if (en[1]) begin
			p_s2  <= ut_full[30:0];
			t2_s2 <= 32'(t_s1) * 32'(t_s1);
			u2_s2 <= 33'(u_s1) * 33'(u_s1);
		end
		if (en[2]) begin
			xr_s3 <= 63'(p_s2) * 63'(t2_s2);
			xg_s3 <= 62'(p_s2) * 62'(p_s2);
			xb_s3 <= 64'(p_s2) * 64'(u2_s2);
		end
		if (en[3]) begin
			yr_s4 <= 75'(xr_s3) * 75'd2295;
			yg_s4 <= 74'(xg_s3) * 74'd3825;
			yb_s4 <= 77'(xb_s3) * 77'd4335;
		end
		if (en[4]) begin
			red   <= yr_s4[71:64];
			green <= yg_s4[71:64];
			blue  <= yb_s4[72:65];
		end
	end

endmodule

// ----- design/escape_count_palette.sv -----
// channel | signals                        | item
// input   | in_valid, in_ready, count      | one escape count
// output  | out_valid, out_ready, red/g/b  | one RGB pixel
// config  | cfg_wr_en, cfg_index, cfg_data | one register write, no wait
//
// One item per clock while the output is not stalled; the pipeline has one input stage,
// 25 divider stages (one quotient bit per stage, count*360/max_count or
// count/max_count) and five palette stages.
// Reset clears the valid bits and loads palette_mode = 0, max_count = 256.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output only holds back a full pipeline and bubbles are squeezed out.
module escape_count_palette import ecp_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COUNT_WIDTH-1:0] count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]            cfg_data
);

	localparam int NST = 1 + DIV_STEPS + POST_STAGES;
	// compare width: wide enough for both the count and the 16-bit limit
	localparam int CWX = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	logic        palette_mode_q;
	logic [15:0] max_count_q;

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;
	logic [NST-1:0] mode_s;
	logic [NST-1:0] black_s;

	logic [CWX-1:0] cnt_x;
	logic [15:0]    cnt16;
	logic           black_in;
	logic [QW-1:0]  x0_s0;
	logic [QW-1:0]  quo;

	logic [7:0] hue_r, hue_g, hue_b;
	logic [7:0] pol_r, pol_g, pol_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_mode_q <= 1'b0;
			max_count_q    <= MAX_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PALETTE_MODE: palette_mode_q <= cfg_data[0];
				REG_MAX_COUNT:    max_count_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage k loads unless it and every stage after it is full and the
	// output is stalled
	always_comb begin
		logic [NST-1:0] lowmask;
		for (int k = 0; k < NST; k++) begin
			lowmask = (NST'(1) << k) - NST'(1);
			en[k] = out_ready || ((v_q | lowmask) != {NST{1'b1}});
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// inside the set (also every count when max_count is zero): black
	assign cnt_x    = CWX'(count);
	assign black_in = cnt_x >= CWX'(max_count_q);
	assign cnt16    = cnt_x[15:0];

	// per-item mode and black flags ride along with the data
	always_ff @(posedge clk) begin
		if (en[0]) begin
			mode_s[0]  <= palette_mode_q;
			black_s[0] <= black_in;
			// hue wheel divides count*360, gradient divides count alone
			x0_s0 <= palette_mode_q ? QW'(cnt16) : QW'(cnt16) * DEG_FULL;
		end
		for (int k = 1; k < NST; k++) begin
			if (en[k]) begin
				mode_s[k]  <= mode_s[k-1];
				black_s[k] <= black_s[k-1];
			end
		end
	end

	ecp_div u_div (
		.clk  (clk),
		.en   (en[DIV_STEPS:1]),
		.x_in (x0_s0),
		.mc   (max_count_q),
		.quo  (quo)
	);

	ecp_hue u_hue (
		.clk   (clk),
		.en    (en[NST-1:DIV_STEPS+1]),
		.quo   (quo),
		.red   (hue_r),
		.green (hue_g),
		.blue  (hue_b)
	);

	ecp_poly u_poly (
		.clk   (clk),
		.en    (en[NST-1:DIV_STEPS+1]),
		.quo   (quo),
		.red   (pol_r),
		.green (pol_g),
		.blue  (pol_b)
	);

	assign out_valid = v_q[NST-1];

	always_comb begin
		if (black_s[NST-1]) begin
			red   = '0;
			green = '0;
			blue  = '0;
		end else if (mode_s[NST-1]) begin
			red   = pol_r;
			green = pol_g;
			blue  = pol_b;
		end else begin
			red   = hue_r;
			green = hue_g;
			blue  = hue_b;
		end
	end

endmodule

// ----- design/ecp_checker.sv -----
`include "escape_count_palette_assert.svh"

module ecp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// an empty output stage never blocks the input
	`ECP_ASSERT_NOW(a_ready_when_out_empty, clk, arst_n, !out_valid, in_ready)

	// a draining output always lets the pipe move
	`ECP_ASSERT_NOW(a_ready_when_out_taken, clk, arst_n, out_ready, in_ready)

	// stalled pixel holds
	`ECP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue))

endmodule

bind escape_count_palette ecp_checker u_ecp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red       (red),
	.green     (green),
	.blue      (blue)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ecp_pkg::*;

	// pipeline depth of the block: input stage, 25 divider stages, 5 palette stages
	localparam int PIPE_LATENCY = 31;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Golden color mapping plus the queue of pixels still owed by the block.
	class pixel_scoreboard;
		bit          mode;
		logic [15:0] limit;
		pixel_t      owed[$];
		int          errors;
		int          checked;

		function new();
			mode = 1'b0;
			limit = MAX_COUNT_RST;
			errors = 0;
			checked = 0;
		endfunction

		function pixel_t color_of(logic [15:0] cnt);
			pixel_t px;
			logic [63:0] h, sec, f, q, t, tt, uu, ut, hi, lo, x;
			px = '{8'd0, 8'd0, 8'd0};
			if (cnt >= limit)
				return px;
			if (!mode) begin
				h = (64'(cnt) * 360 * 65536) / limit + (64'd172 << 16);
				if (h >= (64'd360 << 16))
					h -= (64'd360 << 16);
				sec = h / (64'd60 << 16);
				f = (h - sec * (64'd60 << 16)) / 60;
				q = (765 * (64'd655360 - 9 * f)) / 64'd2621440;
				t = (765 * (64'd655360 - 9 * (64'd65536 - f))) / 64'd2621440;
				case (sec)
					SEC_0: px = '{V_BYTE, t[7:0], P_BYTE};
					SEC_1: px = '{q[7:0], V_BYTE, P_BYTE};
					SEC_2: px = '{P_BYTE, V_BYTE, t[7:0]};
					SEC_3: px = '{P_BYTE, q[7:0], V_BYTE};
					SEC_4: px = '{t[7:0], P_BYTE, V_BYTE};
					default: px = '{V_BYTE, P_BYTE, q[7:0]};
				endcase
			end else begin
				// exact floor: split the 64-bit product so k*x never overflows
				tt = (64'(cnt) << 16) / limit;
				uu = 64'd65536 - tt;
				ut = uu * tt;
				x = uu * tt * tt * tt;
				hi = x >> 16; lo = x & 64'hFFFF;
				px.red = 8'((2295 * hi + ((2295 * lo) >> 16)) >> 48);
				x = ut * ut;
				hi = x >> 16; lo = x & 64'hFFFF;
				px.green = 8'((3825 * hi + ((3825 * lo) >> 16)) >> 48);
				x = uu * uu * uu * tt;
				hi = x >> 16; lo = x & 64'hFFFF;
				px.blue = 8'((4335 * hi + ((4335 * lo) >> 16)) >> 49);
			end
			return px;
		endfunction

		function void note_count(logic [15:0] cnt);
			owed.push_back(color_of(cnt));
		endfunction

		function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			pixel_t e;
			checked++;
			if (owed.size() == 0) begin
				$display("%0t unexpected pixel %0d %0d %0d", $time, r, g, b);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (r !== e.red) begin
				$display("%0t red exp %0d got %0d", $time, e.red, r);
				errors++;
			end
			if (g !== e.green) begin
				$display("%0t green exp %0d got %0d", $time, e.green, g);
				errors++;
			end
			if (b !== e.blue) begin
				$display("%0t blue exp %0d got %0d", $time, e.blue, b);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red, green, blue;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PALETTE_MODE;
	logic [15:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	int send_idle_pct = 0;   // chance in percent that the sender holds off
	int recv_idle_pct = 0;   // chance in percent that the receiver stalls
	int cycles = 0;
	int sent = 0;

	always #5 clk = ~clk;

	escape_count_palette u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .count(count),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Sample both handshakes at the rising edge; the input side is noted here so
	// the expectation is queued in the same cycle the block takes the item.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready)
			sb.note_count(count);
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(red, green, blue);
	end

	// Receiver: stall pattern changes at the falling edge.
	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// Timeout watchdog.
	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("escape_count_palette verification failed");
			$finish;
		end

	// Present one count and hold it until taken; random hold-off first.
	// Valid stays up after the handshake; the next call or the caller drops it.
	task automatic send_count(logic [15:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		count <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Wait until every owed pixel has come back, then let the pipe drain.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// Only called with the block idle; mirror the write in the scoreboard.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_PALETTE_MODE)
			sb.mode = val[0];
		else if (idx == REG_MAX_COUNT)
			sb.limit = val;
		@(negedge clk);
	endtask

	// Counts skewed toward the interesting part of the range: below the limit,
	// right at it, and the odd random value anywhere in the 16-bit range.
	function automatic logic [15:0] pick_count(logic [15:0] lim);
		int sel;
		sel = $urandom_range(9);
		if (sel < 7 && lim != 0)
			return 16'($urandom_range(lim - 1));
		else if (sel == 7)
			return lim;
		else
			return 16'($urandom);
	endfunction

	initial begin
		logic [15:0] lims[6];
		lims = '{16'd256, 16'd1, 16'd65535, 16'd360, 16'd1000, 16'd7};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings, hue extremes, inside the set, all bits.
		send_count(16'd0);
		send_count(16'd1);
		send_count(16'd255);
		send_count(16'd256);
		send_count(16'hFFFF);
		send_count(16'h5555);
		send_count(16'hAAAA);
		for (int s = 0; s < 6; s++)
			send_count(16'((s * 60 * 256 + 30 * 256) / 360));  // one count per hue sector
		drain();
		write_reg(REG_MAX_COUNT, 16'd65535);
		send_count(16'd65534);
		send_count(16'd65535);
		send_count(16'd32768);
		drain();
		write_reg(REG_PALETTE_MODE, 16'd1);
		send_count(16'd0);
		send_count(16'd16384);
		send_count(16'd32768);
		send_count(16'd65534);
		drain();
		// zero limit: everything is inside
		write_reg(REG_MAX_COUNT, 16'd0);
		send_count(16'd0);
		send_count(16'hFFFF);
		drain();
		write_reg(REG_MAX_COUNT, 16'd1);
		send_count(16'd0);
		send_count(16'd1);
		drain();

		// Random phases: three idling schemes times both modes and several limits.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 88 : 0;
			recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 26 : 0;
			for (int m = 0; m < 2; m++) begin
				for (int k = 0; k < 6; k++) begin
					logic [15:0] lim;
					lim = (k < 5) ? lims[k] : 16'($urandom_range(65535));
					write_reg(REG_PALETTE_MODE, 16'(m));
					write_reg(REG_MAX_COUNT, lim);
					for (int n = 0; n < 50; n++) begin
						send_count(pick_count(lim));
						// a quiet stretch now and then: hold until the pipe is empty
						if (n == 25 && k == 2) begin
							in_valid <= 1'b0;
							while (sb.owed.size() != 0)
								@(negedge clk);
						end
					end
					drain();
				end
			end
		end

		drain();
		$display("sent %0d counts over both palettes, limits 0..65535, three stall mixes",
			sent);
		$display("checked %0d pixels, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("escape_count_palette verification clean");
		else
			$display("escape_count_palette verification failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/ecp_pkg.sv
design/ecp_div.sv
design/ecp_hue.sv
design/ecp_poly.sv
design/escape_count_palette.sv
design/ecp_checker.sv
tb/sv/tb_top.sv
